// ===== sv/vas_pkg.sv =====
package vas_pkg;

  localparam int CW         = 32;
  localparam int VW         = 16;
  localparam int AW         = 56;
  localparam int QW         = 64;
  localparam int NW         = 9;
  localparam int SW         = 8;
  localparam int SLICE_CAP  = 256;
  localparam int FAN_LEN    = 12;
  localparam int DIV_BITS   = 8;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [VW-1:0] vdir_t;
  typedef logic signed [AW-1:0] acc_t;
  typedef logic signed [QW-1:0] quot_t;
  typedef logic [2:0]           corner_t;
  typedef logic [3:0]           edge_t;
  typedef logic [1:0]           axis_t;

  typedef enum logic [2:0] {
    REG_BOX_MIN_X   = 3'd0,
    REG_BOX_MIN_Y   = 3'd1,
    REG_BOX_MIN_Z   = 3'd2,
    REG_BOX_MAX_X   = 3'd3,
    REG_BOX_MAX_Y   = 3'd4,
    REG_BOX_MAX_Z   = 3'd5,
    REG_SLICE_COUNT = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    PL_IDLE,
    PL_DIV,
    PL_SEL
  } plane_st_e;

  typedef enum logic [1:0] {
    PT_IDLE,
    PT_DIV,
    PT_OUT
  } point_st_e;

  localparam coord_t         BOX_LO_RST = coord_t'(-65536);
  localparam coord_t         BOX_HI_RST = coord_t'(65536);
  localparam logic [NW-1:0]  COUNT_RST  = NW'(256);
  localparam logic [3:0]     LAST_SLOT  = 4'(FAN_LEN - 1);
  localparam logic [2:0]     DIV_LAST   = 3'(QW / DIV_BITS - 1);
  localparam acc_t           CMAX       = (acc_t'(1) <<< (CW-1)) - acc_t'(1);
  localparam acc_t           CMIN       = -CMAX - acc_t'(1);

  localparam logic [2:0] FAN_PICK [12] = '{
    3'd0, 3'd1, 3'd2, 3'd0, 3'd2, 3'd3, 3'd0, 3'd3, 3'd4, 3'd0, 3'd4, 3'd5
  };

  localparam edge_t EDGE_ORDER [8][12] = '{
    '{4'd0, 4'd1, 4'd5, 4'd6, 4'd4, 4'd8, 4'd11, 4'd9, 4'd3, 4'd7, 4'd2, 4'd10},
    '{4'd0, 4'd4, 4'd3, 4'd11, 4'd1, 4'd2, 4'd6, 4'd7, 4'd5, 4'd9, 4'd8, 4'd10},
    '{4'd1, 4'd5, 4'd0, 4'd8, 4'd2, 4'd3, 4'd7, 4'd4, 4'd6, 4'd10, 4'd9, 4'd11},
    '{4'd7, 4'd11, 4'd10, 4'd8, 4'd2, 4'd6, 4'd1, 4'd9, 4'd3, 4'd0, 4'd4, 4'd5},
    '{4'd8, 4'd5, 4'd9, 4'd1, 4'd11, 4'd10, 4'd7, 4'd6, 4'd4, 4'd3, 4'd0, 4'd2},
    '{4'd9, 4'd6, 4'd10, 4'd2, 4'd8, 4'd11, 4'd4, 4'd7, 4'd5, 4'd0, 4'd1, 4'd3},
    '{4'd9, 4'd8, 4'd5, 4'd4, 4'd6, 4'd1, 4'd2, 4'd0, 4'd10, 4'd7, 4'd11, 4'd3},
    '{4'd10, 4'd9, 4'd6, 4'd5, 4'd7, 4'd2, 4'd3, 4'd1, 4'd11, 4'd4, 4'd8, 4'd0}
  };

  localparam corner_t EDGE_S [12] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7
  };
  localparam corner_t EDGE_F [12] = '{
    3'd1, 3'd2, 3'd3, 3'd0, 3'd4, 3'd5, 3'd6, 3'd7, 3'd5, 3'd6, 3'd7, 3'd4
  };
  localparam axis_t EDGE_AX [12] = '{
    2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd1
  };

  // bit a set: corner sits on the upper bound of axis a
  localparam logic [2:0] CORNER_HI [8] = '{
    3'b000, 3'b001, 3'b011, 3'b010, 3'b100, 3'b101, 3'b111, 3'b110
  };

  typedef struct {
    coord_t lo[3];
    coord_t hi[3];
  } box_t;

  typedef struct {
    vdir_t         v[3];
    logic [SW-1:0] si;
    logic [NW-1:0] n;
    logic          skip;
    acc_t          dax[3];
    acc_t          depth[8];
    corner_t       far;
    acc_t          maxd;
    acc_t          mind;
    quot_t         prod;
  } dep_t;

  typedef struct {
    vdir_t v[3];
    edge_t pe[6];
    acc_t  t[6];
    logic  dz[6];
  } cut_t;

  typedef struct {
    coord_t p[6][3];
  } pts_t;

  function automatic coord_t sat_coord(input acc_t v);
    if (v > CMAX) return coord_t'(CMAX);
    if (v < CMIN) return coord_t'(CMIN);
    return coord_t'(v);
  endfunction

  function automatic coord_t corner_coord(input box_t b, input corner_t c, input axis_t a);
    return CORNER_HI[c][a] ? b.hi[a] : b.lo[a];
  endfunction

  function automatic logic edge_up(input edge_t e);
    return CORNER_HI[EDGE_F[e]][EDGE_AX[e]];
  endfunction

  function automatic logic in_unit(input acc_t t, input acc_t d);
    if (d > acc_t'(0)) return (t >= acc_t'(0)) && (t < d);
    if (d < acc_t'(0)) return (t <= acc_t'(0)) && (t > d);
    return 1'b0;
  endfunction

endpackage

// ===== sv/vas_in_if.sv =====
interface vas_in_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] view_x;
  logic signed [15:0] view_y;
  logic signed [15:0] view_z;
  logic [7:0]         slice_index;

  modport source (output valid, output view_x, output view_y, output view_z,
                  output slice_index, input ready);
  modport sink (input valid, input view_x, input view_y, input view_z,
                input slice_index, output ready);
endinterface

// ===== sv/vas_out_if.sv =====
interface vas_out_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic signed [31:0] vert_z;
  logic [3:0]         fan_slot;
  logic               last;

  modport source (output valid, output vert_x, output vert_y, output vert_z,
                  output fan_slot, output last, input ready);
  modport sink (input valid, input vert_x, input vert_y, input vert_z,
                input fan_slot, input last, output ready);
endinterface

// ===== sv/vas_div.sv =====
module vas_div import vas_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [QW-1:0] num_i,
  input  logic [VW-1:0] den_i,
  input  logic          neg_i,
  output logic          done_o,
  output quot_t         quot_o
);

  logic          busy_q, done_q;
  logic [2:0]    cnt_q;
  logic [QW-1:0] num_q, num_d;
  logic [VW-1:0] den_q, rem_q, rem_d;
  logic          neg_q;

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [VW:0] r;
    r     = '0;
    num_d = num_q;
    rem_d = rem_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      r     = {rem_d, num_d[QW-1]};
      num_d = {num_d[QW-2:0], 1'b0};
      if (r >= {1'b0, den_q}) begin
        r        = r - {1'b0, den_q};
        num_d[0] = 1'b1;
      end
      rem_d = r[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_LAST) && !start_i;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == DIV_LAST) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(num_q) : $signed(num_q);

endmodule

// ===== sv/vas_depth.sv =====
module vas_depth import vas_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  vas_in_if.sink        slice_i,
  input  box_t          box_i,
  input  logic [NW-1:0] count_i,
  output logic          dep_valid_o,
  input  logic          dep_ready_i,
  output dep_t          dep_o
);

  logic                     en;
  logic                     s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  vdir_t                    vin[3];
  logic [NW-1:0]            n_eff;
  logic                     skip;
  logic signed [VW+CW-1:0]  plo[3], phi[3];
  logic signed [CW:0]       dif[3];
  logic signed [VW+CW:0]    dmul[3];

  vdir_t                    v1_q[3];
  logic [SW-1:0]            si1_q;
  logic [NW-1:0]            n1_q;
  logic                     skip1_q;
  acc_t                     pl1_q[3], ph1_q[3], dax1_q[3];
  dep_t                     s2_q, s3_q, s4_q;
  dep_t                     s3_d, s4_d;

  acc_t                     dsum[8];
  corner_t                  mx1[4], mx2[2], mx3;
  acc_t                     mn1[4], mn2[2], mn3;
  acc_t                     span;
  logic signed [AW+SW:0]    prod;

  assign en            = !s4_v_q || dep_ready_i;
  assign slice_i.ready = en;
  assign vin[0]        = slice_i.view_x;
  assign vin[1]        = slice_i.view_y;
  assign vin[2]        = slice_i.view_z;

  always_comb begin
    n_eff = (count_i > NW'(SLICE_CAP)) ? NW'(SLICE_CAP) : count_i;
    skip  = (n_eff == '0) || ({1'b0, slice_i.slice_index} >= n_eff);
    for (int a = 0; a < 3; a++) begin
      plo[a]  = vin[a] * box_i.lo[a];
      phi[a]  = vin[a] * box_i.hi[a];
      dif[a]  = {box_i.hi[a][CW-1], box_i.hi[a]} - {box_i.lo[a][CW-1], box_i.lo[a]};
      dmul[a] = dif[a] * vin[a];
    end
  end

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      dsum[c] = (CORNER_HI[c][0] ? ph1_q[0] : pl1_q[0])
              + (CORNER_HI[c][1] ? ph1_q[1] : pl1_q[1])
              + (CORNER_HI[c][2] ? ph1_q[2] : pl1_q[2]);
    end
  end

  // max keeps the lower corner on ties
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      mx1[j] = (s2_q.depth[2*j+1] > s2_q.depth[2*j]) ? corner_t'(2*j+1) : corner_t'(2*j);
      mn1[j] = (s2_q.depth[2*j+1] < s2_q.depth[2*j]) ? s2_q.depth[2*j+1] : s2_q.depth[2*j];
    end
    for (int j = 0; j < 2; j++) begin
      mx2[j] = (s2_q.depth[mx1[2*j+1]] > s2_q.depth[mx1[2*j]]) ? mx1[2*j+1] : mx1[2*j];
      mn2[j] = (mn1[2*j+1] < mn1[2*j]) ? mn1[2*j+1] : mn1[2*j];
    end
    mx3 = (s2_q.depth[mx2[1]] > s2_q.depth[mx2[0]]) ? mx2[1] : mx2[0];
    mn3 = (mn2[1] < mn2[0]) ? mn2[1] : mn2[0];
  end

  always_comb begin
    span      = s3_q.maxd - s3_q.mind;
    prod      = span * $signed({1'b0, s3_q.si});
    s3_d      = s2_q;
    s3_d.far  = mx3;
    s3_d.maxd = s2_q.depth[mx3] - acc_t'(1);
    s3_d.mind = mn3 + acc_t'(1);
    s4_d      = s3_q;
    s4_d.prod = quot_t'(prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= slice_i.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        v1_q[a]   <= vin[a];
        pl1_q[a]  <= acc_t'(plo[a]);
        ph1_q[a]  <= acc_t'(phi[a]);
        dax1_q[a] <= acc_t'(dmul[a]);
      end
      si1_q   <= slice_i.slice_index;
      n1_q    <= n_eff;
      skip1_q <= skip;

      s2_q.v     <= v1_q;
      s2_q.si    <= si1_q;
      s2_q.n     <= n1_q;
      s2_q.skip  <= skip1_q;
      s2_q.dax   <= dax1_q;
      s2_q.depth <= dsum;
      s2_q.far   <= '0;
      s2_q.maxd  <= '0;
      s2_q.mind  <= '0;
      s2_q.prod  <= '0;

      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  assign dep_valid_o = s4_v_q;
  assign dep_o       = s4_q;

endmodule

// ===== sv/vas_plane.sv =====
module vas_plane import vas_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  dep_t dep_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cut_t cut_o
);

  plane_st_e     st_q, st_d;
  logic          take, load, out_v_q;
  dep_t          item_q;
  acc_t          plane_q;
  cut_t          cut_q, cut_n;
  logic          div_start, div_done, neg;
  logic [QW-1:0] num;
  quot_t         q;
  edge_t         ek[12];
  acc_t          tk[12], dk[12];
  logic [11:0]   hit;
  logic [3:0]    pk[6];
  logic          ok;

  assign neg       = dep_i.prod[QW-1];
  assign num       = neg ? -dep_i.prod : dep_i.prod;
  assign div_start = take && !dep_i.skip;

  vas_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (VW'(dep_i.n)),
    .neg_i   (neg),
    .done_o  (div_done),
    .quot_o  (q)
  );

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      ek[k]  = EDGE_ORDER[item_q.far][k];
      tk[k]  = plane_q - item_q.depth[EDGE_S[ek[k]]];
      dk[k]  = edge_up(ek[k]) ? item_q.dax[EDGE_AX[ek[k]]] : -item_q.dax[EDGE_AX[ek[k]]];
      hit[k] = in_unit(tk[k], dk[k]);
    end
    ok    = hit[0] || hit[1] || hit[3];
    pk[0] = hit[0] ? 4'd0 : hit[1] ? 4'd1 : 4'd3;
    pk[1] = hit[2] ? 4'd2 : hit[0] ? 4'd0 : hit[1] ? 4'd1 : 4'd3;
    pk[2] = hit[4] ? 4'd4 : hit[5] ? 4'd5 : 4'd7;
    pk[3] = hit[6] ? 4'd6 : hit[4] ? 4'd4 : hit[5] ? 4'd5 : 4'd7;
    pk[4] = hit[8] ? 4'd8 : hit[9] ? 4'd9 : 4'd11;
    pk[5] = hit[10] ? 4'd10 : hit[8] ? 4'd8 : hit[9] ? 4'd9 : 4'd11;
    cut_n.v = item_q.v;
    for (int j = 0; j < 6; j++) begin
      cut_n.pe[j] = ek[pk[j]];
      cut_n.t[j]  = tk[pk[j]];
      cut_n.dz[j] = (item_q.dax[EDGE_AX[ek[pk[j]]]] == '0);
    end
  end

  always_comb begin
    st_d       = st_q;
    take       = 1'b0;
    load       = 1'b0;
    in_ready_o = (st_q == PL_IDLE);
    case (st_q)
      PL_IDLE: begin
        if (in_valid_i) begin
          take = 1'b1;
          if (!dep_i.skip) st_d = PL_DIV;
        end
      end
      PL_DIV: begin
        if (div_done) st_d = PL_SEL;
      end
      PL_SEL: begin
        if (!out_v_q || out_ready_i) begin
          load = ok;
          st_d = PL_IDLE;
        end
      end
      default: st_d = PL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= PL_IDLE;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= dep_i;
    if ((st_q == PL_DIV) && div_done) plane_q <= item_q.mind + acc_t'(q);
    if (load) cut_q <= cut_n;
  end

  assign out_valid_o = out_v_q;
  assign cut_o       = cut_q;

endmodule

// ===== sv/vas_point.sv =====
module vas_point import vas_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cut_t cut_i,
  input  box_t box_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output pts_t pts_o
);

  point_st_e     st_q, st_d;
  logic          take, load, out_v_q;
  cut_t          cut_q;
  pts_t          pts_q, pts_n;
  logic [5:0]    done;
  quot_t         q[6];
  logic [QW-1:0] num[6];
  logic [VW-1:0] den[6];
  logic          neg[6];

  always_comb begin
    vdir_t vd;
    logic [AW-1:0] ta;
    for (int j = 0; j < 6; j++) begin
      vd     = cut_i.v[EDGE_AX[cut_i.pe[j]]];
      ta     = cut_i.t[j][AW-1] ? -cut_i.t[j] : cut_i.t[j];
      num[j] = QW'(ta);
      den[j] = vd[VW-1] ? -vd : vd;
      neg[j] = cut_i.t[j][AW-1] ^ vd[VW-1];
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_lane
    vas_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (take),
      .num_i   (num[j]),
      .den_i   (den[j]),
      .neg_i   (neg[j]),
      .done_o  (done[j]),
      .quot_o  (q[j])
    );
  end

  always_comb begin
    edge_t   e;
    axis_t   ax;
    coord_t  cs, cf;
    acc_t    val;
    for (int j = 0; j < 6; j++) begin
      e  = cut_q.pe[j];
      ax = EDGE_AX[e];
      for (int a = 0; a < 3; a++) begin
        cs = corner_coord(box_i, EDGE_S[e], axis_t'(a));
        cf = corner_coord(box_i, EDGE_F[e], axis_t'(a));
        if (a == int'(ax)) begin
          if (cut_q.dz[j]) val = (acc_t'(cs) <<< 1) - acc_t'(cf);
          else val = acc_t'(cs) + acc_t'(q[j]);
        end else begin
          val = acc_t'(cs);
        end
        pts_n.p[j][a] = sat_coord(val);
      end
    end
  end

  always_comb begin
    st_d       = st_q;
    take       = 1'b0;
    load       = 1'b0;
    in_ready_o = (st_q == PT_IDLE);
    case (st_q)
      PT_IDLE: begin
        if (in_valid_i) begin
          take = 1'b1;
          st_d = PT_DIV;
        end
      end
      PT_DIV: begin
        if (&done) st_d = PT_OUT;
      end
      PT_OUT: begin
        if (!out_v_q || out_ready_i) begin
          load = 1'b1;
          st_d = PT_IDLE;
        end
      end
      default: st_d = PT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= PT_IDLE;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cut_q <= cut_i;
    if (load) pts_q <= pts_n;
  end

  assign out_valid_o = out_v_q;
  assign pts_o       = pts_q;

endmodule

// ===== sv/vas_emit.sv =====
module vas_emit import vas_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  pts_t      pts_i,
  vas_out_if.source vert_o
);

  logic       busy_q, out_v_q;
  logic [3:0] cnt_q;
  pts_t       pts_q;
  coord_t     x_q, y_q, z_q;
  logic [3:0] slot_q;
  logic       last_q;
  logic       emit, fin, take;

  assign emit       = busy_q && (!out_v_q || vert_o.ready);
  assign fin        = emit && (cnt_q == LAST_SLOT);
  assign in_ready_o = !busy_q || fin;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      out_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (fin) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (emit) out_v_q <= 1'b1;
      else if (vert_o.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) pts_q <= pts_i;
    if (emit) begin
      x_q    <= pts_q.p[FAN_PICK[cnt_q]][0];
      y_q    <= pts_q.p[FAN_PICK[cnt_q]][1];
      z_q    <= pts_q.p[FAN_PICK[cnt_q]][2];
      slot_q <= cnt_q;
      last_q <= (cnt_q == LAST_SLOT);
    end
  end

  assign vert_o.valid    = out_v_q;
  assign vert_o.vert_x   = x_q;
  assign vert_o.vert_y   = y_q;
  assign vert_o.vert_z   = z_q;
  assign vert_o.fan_slot = slot_q;
  assign vert_o.last     = last_q;

endmodule

// ===== sv/view_aligned_volume_slicer.sv =====
// channel   dir  payload                                   transfer when
// slice_i   in   view_x/y/z Q1.14, slice_index             valid && ready
// vert_o    out  vert_x/y/z Q16.16, fan_slot, last         valid && ready
// cfg       in   cfg_idx_i, cfg_data_i                     cfg_we_i
//
// Throughput: the fan emitter sends one vertex per cycle within a slice while vert_o is ready.
// The plane and point units each hold one slice at a time and take the next only when idle.
// Reset clears all valid and state flags; config returns to the +-1.0 box, 256 slices.
// Stalls on vert_o back up through all units without loss or repeat.
module view_aligned_volume_slicer import vas_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  vas_in_if.sink      slice_i,
  vas_out_if.source   vert_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  box_t          box_q;
  logic [NW-1:0] count_q;
  logic          dep_v, dep_rdy, cut_v, cut_rdy, pts_v, pts_rdy;
  dep_t          dep;
  cut_t          cut;
  pts_t          pts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        box_q.lo[a] <= BOX_LO_RST;
        box_q.hi[a] <= BOX_HI_RST;
      end
      count_q <= COUNT_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_BOX_MIN_X:   box_q.lo[0] <= cfg_data_i;
        REG_BOX_MIN_Y:   box_q.lo[1] <= cfg_data_i;
        REG_BOX_MIN_Z:   box_q.lo[2] <= cfg_data_i;
        REG_BOX_MAX_X:   box_q.hi[0] <= cfg_data_i;
        REG_BOX_MAX_Y:   box_q.hi[1] <= cfg_data_i;
        REG_BOX_MAX_Z:   box_q.hi[2] <= cfg_data_i;
        REG_SLICE_COUNT: count_q     <= cfg_data_i[NW-1:0];
        default: ;
      endcase
    end
  end

  vas_depth u_depth (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slice_i     (slice_i),
    .box_i       (box_q),
    .count_i     (count_q),
    .dep_valid_o (dep_v),
    .dep_ready_i (dep_rdy),
    .dep_o       (dep)
  );

  vas_plane u_plane (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dep_v),
    .in_ready_o  (dep_rdy),
    .dep_i       (dep),
    .out_valid_o (cut_v),
    .out_ready_i (cut_rdy),
    .cut_o       (cut)
  );

  vas_point u_point (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cut_v),
    .in_ready_o  (cut_rdy),
    .cut_i       (cut),
    .box_i       (box_q),
    .out_valid_o (pts_v),
    .out_ready_i (pts_rdy),
    .pts_o       (pts)
  );

  vas_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pts_v),
    .in_ready_o (pts_rdy),
    .pts_i      (pts),
    .vert_o     (vert_o)
  );

endmodule

// ===== verif/tb_view_aligned_volume_slicer.sv =====
module tb_view_aligned_volume_slicer;
  import vas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 60;
  localparam int HOLD_LEN    = 400;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [3:0]  slot;
    logic        last;
  } vert_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  vas_in_if  in_if ();
  vas_out_if out_if ();

  view_aligned_volume_slicer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .slice_i    (in_if),
    .vert_o     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  vert_t        vert_queue[$];
  longint       box_lo[3];
  longint       box_hi[3];
  logic [8:0]   slice_cnt;
  int           tx_idle = 0;
  int           rx_idle = 0;
  int           errors = 0;
  int           cycles = 0;
  bit           hold_go = 1'b0;
  bit           hold_seen = 1'b0;
  int           hold_cnt = 0;

  initial begin
    in_if.valid       = 1'b0;
    in_if.view_x      = '0;
    in_if.view_y      = '0;
    in_if.view_z      = '0;
    in_if.slice_index = '0;
    out_if.ready      = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen    <= hold_go;
      hold_cnt     <= HOLD_LEN;
      out_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // outputs settle between edges; a transfer seen here completes at the next edge
  always @(negedge clk_i) begin
    vert_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.vert_x, out_if.vert_y, out_if.vert_z, out_if.fan_slot, out_if.last};
      if (vert_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected vertex %h", got);
      end else begin
        want = vert_queue.pop_front();
        if (got.x != want.x || got.y != want.y || got.z != want.z ||
            got.slot != want.slot || got.last != want.last) begin
          errors++;
          if (errors <= 10)
            $display("vertex mismatch: exp x=%h y=%h z=%h slot=%0d last=%b, got x=%h y=%h z=%h slot=%0d last=%b",
                     want.x, want.y, want.z, want.slot, want.last,
                     got.x, got.y, got.z, got.slot, got.last);
        end
      end
    end
  end

  function automatic longint clamp32(longint val);
    if (val > 64'sd2147483647) return 64'sd2147483647;
    if (val < -64'sd2147483648) return -64'sd2147483648;
    return val;
  endfunction

  task automatic predict_slice(input logic signed [15:0] vx, vy, vz, input logic [7:0] si);
    longint v[3];
    longint c[8][3];
    longint dep[8];
    longint pt[12][3];
    longint maxd, mind, plane, diff, d, t;
    bit     hit[12];
    int     n, far, e, s, f, ax, src;
    int     poly[6];
    n = slice_cnt;
    if (n > SLICE_CAP) n = SLICE_CAP;
    if (n == 0 || int'(si) >= n) return;
    v[0] = vx; v[1] = vy; v[2] = vz;
    for (int i = 0; i < 8; i++) begin
      dep[i] = 0;
      for (int a = 0; a < 3; a++) begin
        c[i][a] = CORNER_HI[i][a] ? box_hi[a] : box_lo[a];
        dep[i] += v[a] * c[i][a];
      end
    end
    far = 0; maxd = dep[0]; mind = dep[0];
    for (int i = 1; i < 8; i++) begin
      if (dep[i] > maxd) begin maxd = dep[i]; far = i; end
      if (dep[i] < mind) mind = dep[i];
    end
    maxd -= 1;
    mind += 1;
    plane = mind + ((maxd - mind) * longint'(si)) / longint'(n);
    for (int k = 0; k < 12; k++) begin
      e = EDGE_ORDER[far][k];
      s = EDGE_S[e];
      f = EDGE_F[e];
      ax = EDGE_AX[e];
      diff = c[f][ax] - c[s][ax];
      d = diff * v[ax];
      t = plane - dep[s];
      for (int a = 0; a < 3; a++) pt[k][a] = c[s][a];
      hit[k] = (d > 0) ? (t >= 0 && t < d) : (d < 0) ? (t <= 0 && t > d) : 1'b0;
      pt[k][ax] = (d == 0) ? c[s][ax] - diff : c[s][ax] + t / v[ax];
      for (int a = 0; a < 3; a++) pt[k][a] = clamp32(pt[k][a]);
    end
    if (hit[0]) poly[0] = 0;
    else if (hit[1]) poly[0] = 1;
    else if (hit[3]) poly[0] = 3;
    else return;
    poly[1] = hit[2] ? 2 : hit[0] ? 0 : hit[1] ? 1 : 3;
    poly[2] = hit[4] ? 4 : hit[5] ? 5 : 7;
    poly[3] = hit[6] ? 6 : hit[4] ? 4 : hit[5] ? 5 : 7;
    poly[4] = hit[8] ? 8 : hit[9] ? 9 : 11;
    poly[5] = hit[10] ? 10 : hit[8] ? 8 : hit[9] ? 9 : 11;
    for (int k = 0; k < FAN_LEN; k++) begin
      src = poly[FAN_PICK[k]];
      vert_queue.push_back('{pt[src][0][31:0], pt[src][1][31:0], pt[src][2][31:0],
                             4'(k), (k == FAN_LEN - 1)});
    end
  endtask

  task automatic send_slice(input logic signed [15:0] vx, vy, vz, input logic [7:0] si);
    bit fire;
    while ($urandom_range(99) < tx_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    predict_slice(vx, vy, vz, si);
    in_if.valid       <= 1'b1;
    in_if.view_x      <= vx;
    in_if.view_y      <= vy;
    in_if.view_z      <= vz;
    in_if.slice_index <= si;
    do begin
      @(negedge clk_i);
      fire = in_if.ready;
      @(posedge clk_i);
    end while (!fire);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (vert_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == REG_SLICE_COUNT) slice_cnt = data[8:0];
    else if (idx <= REG_BOX_MIN_Z) box_lo[idx] = longint'($signed(data));
    else box_hi[idx - REG_BOX_MAX_X] = longint'($signed(data));
    @(posedge clk_i);
  endtask

  task automatic load_box(input logic [31:0] lx, ly, lz, hx, hy, hz, input logic [8:0] cnt);
    drain();
    write_reg(REG_BOX_MIN_X, lx);
    write_reg(REG_BOX_MIN_Y, ly);
    write_reg(REG_BOX_MIN_Z, lz);
    write_reg(REG_BOX_MAX_X, hx);
    write_reg(REG_BOX_MAX_Y, hy);
    write_reg(REG_BOX_MAX_Z, hz);
    write_reg(REG_SLICE_COUNT, {23'd0, cnt});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_view();
    case ($urandom_range(9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_bound(input bit upper);
    case ($urandom_range(9))
      0: return $urandom();
      1: return upper ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(1 << 19)) - (upper ? 0 : (1 << 19)));
    endcase
  endfunction

  function automatic logic [8:0] rand_count();
    case ($urandom_range(9))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd511;
      3: return 9'd256;
      default: return 9'($urandom_range(2, 300));
    endcase
  endfunction

  function automatic logic [7:0] rand_index();
    int lim;
    lim = (slice_cnt > SLICE_CAP) ? SLICE_CAP : slice_cnt;
    if (lim == 0 || $urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(lim - 1));
  endfunction

  task automatic test_directed();
    load_box(32'hffff0000, 32'hffff0000, 32'hffff0000,
             32'h00010000, 32'h00010000, 32'h00010000, 9'd256);
    send_slice(16384, 0, 0, 0);
    send_slice(-16384, 0, 0, 128);
    send_slice(0, 16384, 0, 255);
    send_slice(0, -16384, 0, 7);
    send_slice(0, 0, 16384, 100);
    send_slice(0, 0, -16384, 200);
    send_slice(9459, 9459, 9459, 64);
    send_slice(-9459, 9459, -9459, 191);
    send_slice(0, 0, 0, 3);
    send_slice(16384, -16384, 16384, 255);
    send_slice(-16384, -16384, -16384, 0);
    send_slice(1, -1, 2, 50);
    load_box(32'h00010000, 32'h00000000, 32'h00020000,
             32'hffff0000, 32'h00000000, 32'hfffe0000, 9'd0);
    send_slice(16384, 8000, -300, 0);
    load_box(32'h80000000, 32'h80000000, 32'h80000000,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 9'd511);
    send_slice(16384, 16384, 16384, 255);
    send_slice(-16384, 5000, 16384, 0);
    send_slice(123, -16384, 7777, 131);
    load_box(32'h00010000, 32'h00000000, 32'h00020000,
             32'hffff0000, 32'h00000000, 32'hfffe0000, 9'd1);
    send_slice(16384, 8000, -300, 0);
    send_slice(-4000, 16384, 12000, 0);
    send_slice(16384, 8000, -300, 1);
    load_box(32'h00000000, 32'h00000000, 32'h00000000,
             32'h00000000, 32'h00000000, 32'h00000000, 9'd2);
    send_slice(16384, 16384, 16384, 1);
  endtask

  task automatic test_random(input int count);
    logic signed [15:0] vx, vy, vz;
    for (int i = 0; i < count; i++) begin
      if (i % 17 == 0)
        load_box(rand_bound(0), rand_bound(0), rand_bound(0),
                 rand_bound(1), rand_bound(1), rand_bound(1), rand_count());
      vx = rand_view();
      vy = rand_view();
      vz = rand_view();
      send_slice(vx, vy, vz, rand_index());
    end
  endtask

  task automatic test_backpressure();
    load_box(32'hfffe0000, 32'hffff8000, 32'hffff0000,
             32'h00020000, 32'h00008000, 32'h00030000, 9'd64);
    tx_idle = 0;
    hold_go = ~hold_go;
    for (int i = 0; i < 30; i++)
      send_slice(16'($signed($urandom_range(32768)) - 16384),
                 16'($signed($urandom_range(32768)) - 16384),
                 16384, 8'($urandom_range(63)));
  endtask

  initial begin
    slice_cnt = COUNT_RST;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = BOX_LO_RST;
      box_hi[a] = BOX_HI_RST;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle = 17; rx_idle = 66;
    test_directed();
    test_random(33);
    tx_idle = 66; rx_idle = 17;
    test_random(33);
    tx_idle = 0; rx_idle = 0;
    test_random(33);
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/vas_pkg.sv
sv/vas_in_if.sv
sv/vas_out_if.sv
sv/vas_div.sv
sv/vas_depth.sv
sv/vas_plane.sv
sv/vas_point.sv
sv/vas_emit.sv
sv/view_aligned_volume_slicer.sv
verif/tb_view_aligned_volume_slicer.sv
